// ===== hdl/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Status codes and shared constants of the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  // pool geometry; port widths of the top level are sized for these values
  localparam int BLOCKS_PER_CHUNK = 64;
  localparam int BLOCK_BYTES      = 65536;
  localparam int MAX_CHUNKS       = 8;
  localparam int NUM_CLASSES      = 4;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO      = 3'd1,
    ST_LARGE     = 3'd2,
    ST_EXHAUSTED = 3'd3,
    ST_BAD_FREE  = 3'd4
  } status_t;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

endpackage

// ===== hdl/block_bitmap_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// block_bitmap_allocator_unit
// First-fit bitmap block allocator over a memory of chunk bitmaps.
// ----------------------------------------------------------------------------
// Rejected words go straight to the result; a free rewrites one chunk word;
// allocate scans active chunks, else opens one. Next word is taken at the result edge.
// Throughput: one word at a time; the bitmap memory read/modify/write sets the pace.
// Reset: sync active low; no clearing pass. Per-chunk valid bits give the
// all-free map and zero offset for chunks not yet written.
// Results leave on a one-cycle strobe; the receiver cannot stall.
module block_bitmap_allocator_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_operation,
  input  logic [1:0] in_alignment_class,
  input  logic [31:0] in_size_bytes,
  input  logic [2:0] in_free_chunk,
  input  logic [5:0] in_free_start,
  input  logic [6:0] in_free_count,
  output logic       out_valid,
  output logic [2:0] out_status,
  output logic [2:0] out_chunk_id,
  output logic [5:0] out_start_block,
  output logic [6:0] out_block_count,
  output logic       out_new_chunk
);

  localparam int BLOCKS_PER_CHUNK = bba_pkg::BLOCKS_PER_CHUNK;
  localparam int BLOCK_BYTES      = bba_pkg::BLOCK_BYTES;
  localparam int MAX_CHUNKS       = bba_pkg::MAX_CHUNKS;
  localparam int NUM_CLASSES      = bba_pkg::NUM_CLASSES;

  localparam int NB   = BLOCKS_PER_CHUNK;
  localparam int OW   = $clog2(NB + 1);
  localparam int CW   = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int AW   = $clog2(MAX_CHUNKS + 1);
  localparam int KW   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int DEP  = NUM_CLASSES * MAX_CHUNKS;
  localparam int MW   = (DEP > 1) ? $clog2(DEP) : 1;
  localparam int SH   = $clog2(BLOCK_BYTES);
  localparam int NQW  = 33 - SH;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RD    = 6'b000010,
    S_CHK   = 6'b000100,
    S_WR    = 6'b001000,
    S_OUT   = 6'b010000,
    S_FREE  = 6'b100000
  } state_t;

  // bitmap (1 = free) and search offset live in one memory word
  logic [NB+OW-1:0] mem [DEP];
  logic [NB+OW-1:0] rd_r;
  logic             mem_we;
  logic [MW-1:0]    mem_wa, mem_ra;
  logic [NB+OW-1:0] mem_wd;
  logic [DEP-1:0]   wvld_r, wvld_nxt;
  logic             rdv_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_r <= mem[mem_ra];
  end

  state_t st_r, st_nxt;
  logic [AW-1:0] act_r [NUM_CLASSES];
  logic [AW-1:0] act_nxt [NUM_CLASSES];
  logic          op_r, op_nxt;
  logic [KW-1:0] cls_r, cls_nxt;
  logic [6:0]    need_r, need_nxt;
  logic [CW-1:0] ch_r, ch_nxt;
  logic [5:0]    fst_r, fst_nxt;
  logic [6:0]    fcnt_r, fcnt_nxt;
  logic [2:0]    o_st_r, o_st_nxt, o_ch_r, o_ch_nxt;
  logic [5:0]    o_sb_r, o_sb_nxt;
  logic [6:0]    o_bc_r, o_bc_nxt;
  logic          o_nc_r, o_nc_nxt, o_v_r, o_v_nxt;
  logic [NB+OW-1:0] wd_r, wd_nxt;

  // effective word: unwritten chunks read all free, offset zero
  logic [NB-1:0] map;
  logic [OW-1:0] off;
  always_comb begin
    map = rdv_r ? rd_r[NB-1:0] : {NB{1'b1}};
    off = rdv_r ? rd_r[NB+OW-1:NB] : '0;
  end

  // first fit at/after offset: lowest start whose need-long window is free
  logic          fit;
  logic [OW-1:0] fstart;
  logic [NB-1:0] okmask;
  always_comb begin
    logic [NB-1:0] win;
    fit = 1'b0;
    fstart = '0;
    win = '0;
    for (int j = 0; j < NB; j++) begin
      okmask[j] = map[j] && (OW'(j) >= off);
    end
    for (int s = NB - 1; s >= 0; s--) begin
      for (int k = 0; k < NB; k++)
        win[k] = (k >= s) && (k < s + int'(need_r));
      if ((s + int'(need_r) <= NB) && ((okmask & win) == win)) begin
        fit = 1'b1;
        fstart = OW'(s);
      end
    end
  end

  logic [NB-1:0] runmask;
  always_comb begin
    for (int k = 0; k < NB; k++)
      runmask[k] = (OW'(k) >= fstart) && ({1'b0, OW'(k)} < {1'b0, fstart} + (OW+1)'(need_r));
  end

  logic [NB-1:0] frmask;
  always_comb begin
    for (int k = 0; k < NB; k++)
      frmask[k] = (k >= int'(fst_r)) && (k < int'(fst_r) + int'(fcnt_r));
  end

  logic [NQW-1:0] nq;
  assign nq = NQW'(({1'b0, in_size_bytes} + 33'(BLOCK_BYTES - 1)) >> SH);

  always_comb begin
    st_nxt = st_r;
    op_nxt = op_r; cls_nxt = cls_r; need_nxt = need_r; ch_nxt = ch_r;
    fst_nxt = fst_r; fcnt_nxt = fcnt_r;
    o_st_nxt = o_st_r; o_ch_nxt = o_ch_r; o_sb_nxt = o_sb_r; o_bc_nxt = o_bc_r;
    o_nc_nxt = o_nc_r; o_v_nxt = 1'b0; wd_nxt = wd_r;
    wvld_nxt = wvld_r;
    for (int c = 0; c < NUM_CLASSES; c++) act_nxt[c] = act_r[c];
    mem_we = 1'b0; mem_wa = MW'(cls_r * MAX_CHUNKS + ch_r); mem_wd = wd_r;
    mem_ra = MW'(cls_r * MAX_CHUNKS + ch_r);
    case (st_r)
      S_IDLE: begin
        if (start) begin
          op_nxt = in_operation;
          cls_nxt = KW'(in_alignment_class);
          fst_nxt = in_free_start; fcnt_nxt = in_free_count;
          need_nxt = 7'(nq);
          ch_nxt = '0;
          o_st_nxt = bba_pkg::ST_OK; o_ch_nxt = '0; o_sb_nxt = '0; o_bc_nxt = '0;
          o_nc_nxt = 1'b0;
          st_nxt = S_OUT;
          if (in_operation == bba_pkg::OP_FREE) begin
            if ((32'(in_alignment_class) >= NUM_CLASSES) ||
                (32'(in_free_chunk) >= MAX_CHUNKS) ||
                (4'(in_free_chunk) >= 4'(act_r[KW'(in_alignment_class)])) ||
                (in_free_count == 7'd0) ||
                (32'(in_free_start) + 32'(in_free_count) > NB))
              o_st_nxt = bba_pkg::ST_BAD_FREE;
            else begin
              ch_nxt = CW'(in_free_chunk);
              mem_ra = MW'(KW'(in_alignment_class) * MAX_CHUNKS + CW'(in_free_chunk));
              st_nxt = S_FREE;
            end
          end else if (in_size_bytes == 32'd0) o_st_nxt = bba_pkg::ST_ZERO;
          else if (NQW'(nq) > NQW'(NB)) o_st_nxt = bba_pkg::ST_LARGE;
          else if (32'(in_alignment_class) >= NUM_CLASSES) o_st_nxt = bba_pkg::ST_EXHAUSTED;
          else begin
            mem_ra = MW'(KW'(in_alignment_class) * MAX_CHUNKS);
            st_nxt = S_CHK;
            if (act_r[KW'(in_alignment_class)] == '0) st_nxt = S_WR;
          end
        end
      end
      S_FREE: begin
        wd_nxt = {OW'(fst_r), map | frmask};
        o_ch_nxt = 3'(ch_r); o_sb_nxt = fst_r; o_bc_nxt = fcnt_r;
        st_nxt = S_WR;
      end
      S_RD: begin
        st_nxt = S_CHK;
      end
      S_CHK: begin
        if ((OW+1)'(need_r) <= (OW+1)'(NB) - (OW+1)'(off) && fit) begin
          wd_nxt = {OW'(off + OW'(need_r)), map & ~runmask};
          o_ch_nxt = 3'(ch_r); o_sb_nxt = 6'(fstart); o_bc_nxt = need_r;
          st_nxt = S_WR;
        end else if (AW'(ch_r) + 1'b1 < act_r[cls_r]) begin
          ch_nxt = ch_r + 1'b1;
          mem_ra = MW'(cls_r * MAX_CHUNKS + CW'(ch_r + 1'b1));
          st_nxt = S_RD;
        end else if (act_r[cls_r] >= AW'(MAX_CHUNKS)) begin
          o_st_nxt = bba_pkg::ST_EXHAUSTED;
          st_nxt = S_OUT;
        end else begin
          ch_nxt = CW'(act_r[cls_r]);
          st_nxt = S_WR;
        end
      end
      S_WR: begin
        // fresh chunk: build word without reading memory
        if (op_r == bba_pkg::OP_ALLOC && (AW'(ch_r) == act_r[cls_r] ||
            (act_r[cls_r] == '0))) begin
          ch_nxt = ch_r;
          mem_wd = {OW'(need_r), {NB{1'b1}} & ~(~({NB{1'b1}} << need_r))};
          if (need_r >= 7'(NB) ) mem_wd = {OW'(need_r), {NB{1'b0}}};
          mem_wa = MW'(cls_r * MAX_CHUNKS + ch_r);
          act_nxt[cls_r] = act_r[cls_r] + 1'b1;
          o_ch_nxt = 3'(ch_r); o_sb_nxt = '0; o_bc_nxt = need_r; o_nc_nxt = 1'b1;
        end
        mem_we = 1'b1;
        wvld_nxt[mem_wa] = 1'b1;
        st_nxt = S_OUT;
      end
      S_OUT: begin
        o_v_nxt = 1'b1;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      wvld_r <= '0;
      o_v_r <= 1'b0;
      rdv_r <= 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) act_r[c] <= '0;
    end else begin
      st_r <= st_nxt;
      wvld_r <= wvld_nxt;
      o_v_r <= o_v_nxt;
      rdv_r <= wvld_r[mem_ra];
      for (int c = 0; c < NUM_CLASSES; c++) act_r[c] <= act_nxt[c];
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt; cls_r <= cls_nxt; need_r <= need_nxt; ch_r <= ch_nxt;
    fst_r <= fst_nxt; fcnt_r <= fcnt_nxt; wd_r <= wd_nxt;
    o_st_r <= o_st_nxt; o_ch_r <= o_ch_nxt; o_sb_r <= o_sb_nxt;
    o_bc_r <= o_bc_nxt; o_nc_r <= o_nc_nxt;
  end

  // result registers are already loaded, so a new word may enter on the strobe cycle
  assign busy            = (st_r != S_IDLE);
  assign out_valid       = o_v_r;
  assign out_status      = o_st_r;
  assign out_chunk_id    = o_ch_r;
  assign out_start_block = o_sb_r;
  assign out_block_count = o_bc_r;
  assign out_new_chunk   = o_nc_r;

endmodule

// ===== sim/tb_block_bitmap_allocator_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_block_bitmap_allocator_unit
// Drives allocate and free words into the bitmap allocator and checks every
// result against a behavioral first-fit model kept in the testbench.
// ----------------------------------------------------------------------------
module tb_block_bitmap_allocator_unit;

  localparam int BPC     = bba_pkg::BLOCKS_PER_CHUNK;
  localparam int BLK_B   = bba_pkg::BLOCK_BYTES;
  localparam int NCHUNK  = bba_pkg::MAX_CHUNKS;
  localparam int NCLASS  = bba_pkg::NUM_CLASSES;
  localparam int N_RAND  = 1950;
  localparam int WD_LIMIT = 20000;

  typedef struct packed {
    logic        op;
    logic [1:0]  cls;
    logic [31:0] size;
    logic [2:0]  fch;
    logic [5:0]  fst;
    logic [6:0]  fcnt;
  } req_t;

  typedef struct packed {
    bba_pkg::status_t st;
    logic [2:0] ch;
    logic [5:0] sb;
    logic [6:0] cnt;
    logic       fresh;
  } resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_operation = 1'b0;
  logic [1:0] in_alignment_class = '0;
  logic [31:0] in_size_bytes = '0;
  logic [2:0] in_free_chunk = '0;
  logic [5:0] in_free_start = '0;
  logic [6:0] in_free_count = '0;
  logic out_valid;
  logic [2:0] out_status, out_chunk_id;
  logic [5:0] out_start_block;
  logic [6:0] out_block_count;
  logic out_new_chunk;

  block_bitmap_allocator_unit dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // allocator shadow state
  logic [BPC-1:0] map_q [NCLASS][NCHUNK];
  int unsigned    ofs_q [NCLASS][NCHUNK];
  int unsigned    act_q [NCLASS];

  req_t  pend_q[$];
  resp_t alloc_exp_q[$];
  int    errs = 0;
  bit    stim_done = 0;
  int    gap = 0;
  int    idle_cyc = 0;

  function automatic resp_t compute_alloc(req_t r);
    resp_t o;
    longint unsigned need;
    int unsigned run_s, run_l, i, c;
    o = '{st: bba_pkg::ST_OK, ch: '0, sb: '0, cnt: '0, fresh: 1'b0};
    if (r.op == bba_pkg::OP_FREE) begin
      if (r.fch >= act_q[r.cls] || r.fcnt == 0 || r.fst + r.fcnt > BPC) begin
        o.st = bba_pkg::ST_BAD_FREE;
        return o;
      end
      for (i = 32'(r.fst); i < r.fst + r.fcnt; i++) map_q[r.cls][r.fch][i] = 1'b1;
      ofs_q[r.cls][r.fch] = 32'(r.fst);
      o.ch = r.fch; o.sb = r.fst; o.cnt = r.fcnt;
      return o;
    end
    if (r.size == 0) begin
      o.st = bba_pkg::ST_ZERO;
      return o;
    end
    need = (longint'(r.size) + BLK_B - 1) / BLK_B;
    if (need > BPC) begin
      o.st = bba_pkg::ST_LARGE;
      return o;
    end
    for (c = 0; c < act_q[r.cls]; c++) begin
      if (need > BPC - ofs_q[r.cls][c]) continue;
      run_s = ofs_q[r.cls][c];
      run_l = 0;
      for (i = ofs_q[r.cls][c]; i < BPC; i++) begin
        if (map_q[r.cls][c][i]) begin
          run_l++;
          if (run_l == need) break;
        end else begin
          run_s = i + 1;
          run_l = 0;
        end
      end
      if (run_l == need) begin
        for (i = run_s; i < run_s + need; i++) map_q[r.cls][c][i] = 1'b0;
        ofs_q[r.cls][c] += 32'(need);
        o.ch = 3'(c); o.sb = 6'(run_s); o.cnt = 7'(need);
        return o;
      end
    end
    if (act_q[r.cls] >= NCHUNK) begin
      o.st = bba_pkg::ST_EXHAUSTED;
      return o;
    end
    c = act_q[r.cls];
    act_q[r.cls]++;
    for (i = 0; i < need; i++) map_q[r.cls][c][i] = 1'b0;
    ofs_q[r.cls][c] = 32'(need);
    o.ch = 3'(c); o.cnt = 7'(need); o.fresh = 1'b1;
    return o;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // mostly small sizes so pools fill and then free back up
  function automatic logic [31:0] rand_size();
    int p;
    p = $urandom_range(0, 99);
    if (p < 3) return 0;
    if (p < 6) return $urandom();
    if (p < 10) return BPC * BLK_B + $urandom_range(0, 1);
    if (p < 80) return $urandom_range(1, 4 * BLK_B);
    return $urandom_range(1, BPC * BLK_B);
  endfunction

  task automatic push(input logic op, input logic [1:0] cls, input logic [31:0] sz,
                      input logic [2:0] fch, input logic [5:0] fst, input logic [6:0] fcnt);
    pend_q.push_back('{op: op, cls: cls, size: sz, fch: fch, fst: fst, fcnt: fcnt});
  endtask

  initial begin
    int k;
    for (int a = 0; a < NCLASS; a++) begin
      act_q[a] = 0;
      for (int b = 0; b < NCHUNK; b++) begin
        map_q[a][b] = '1;
        ofs_q[a][b] = 0;
      end
    end
    // directed words
    push(bba_pkg::OP_FREE, 2'd0, 32'd0, 3'd0, 6'd0, 7'd1);          // free of inactive chunk
    push(bba_pkg::OP_ALLOC, 2'd0, 32'd0, 3'd0, 6'd0, 7'd0);         // zero size
    push(bba_pkg::OP_ALLOC, 2'd0, 32'hFFFF_FFFF, 3'd0, 6'd0, 7'd0); // too large
    push(bba_pkg::OP_ALLOC, 2'd0, BPC * BLK_B + 1, 3'd0, 6'd0, 7'd0); // one byte past
    push(bba_pkg::OP_ALLOC, 2'd0, 32'd1, 3'd0, 6'd0, 7'd0);         // new chunk
    push(bba_pkg::OP_ALLOC, 2'd0, 62 * BLK_B, 3'd0, 6'd0, 7'd0);    // up to chunk end - 1
    push(bba_pkg::OP_ALLOC, 2'd0, BLK_B, 3'd0, 6'd0, 7'd0);         // run ending at end
    push(bba_pkg::OP_ALLOC, 2'd1, BPC * BLK_B, 3'd0, 6'd0, 7'd0);   // whole chunk
    push(bba_pkg::OP_FREE, 2'd0, 32'd0, 3'd0, 6'd0, 7'd0);          // zero count
    push(bba_pkg::OP_FREE, 2'd0, 32'd0, 3'd0, 6'd63, 7'd2);         // past chunk end
    push(bba_pkg::OP_FREE, 2'd0, 32'd0, 3'd0, 6'd10, 7'd5);
    push(bba_pkg::OP_FREE, 2'd0, 32'd0, 3'd0, 6'd10, 7'd5);         // already free
    push(bba_pkg::OP_ALLOC, 2'd0, 3 * BLK_B, 3'd0, 6'd0, 7'd0);
    push(bba_pkg::OP_FREE, 2'd0, 32'd0, 3'd0, 6'd0, 7'd64);
    push(bba_pkg::OP_FREE, 2'd3, 32'd0, 3'd7, 6'd63, 7'd127);
    // exhaust a class
    for (k = 0; k < 9; k++)
      push(bba_pkg::OP_ALLOC, 2'd2, BPC * BLK_B, 3'd0, 6'd0, 7'd0);
    push(bba_pkg::OP_FREE, 2'd2, 32'd0, 3'd7, 6'd0, 7'd64);
    // random words
    for (k = 0; k < N_RAND; k++) begin
      if ($urandom_range(0, 99) < 60) begin
        push(bba_pkg::OP_ALLOC, 2'($urandom()), rand_size(), 3'($urandom()),
             6'($urandom()), 7'($urandom()));
      end else if ($urandom_range(0, 9) < 8) begin
        int s;
        s = $urandom_range(0, 63);
        push(bba_pkg::OP_FREE, 2'($urandom()), $urandom(), 3'($urandom_range(0, 7)), 6'(s),
             7'($urandom_range(1, 64 - s)));
      end else begin
        push(bba_pkg::OP_FREE, 2'($urandom()), $urandom(), 3'($urandom()), 6'($urandom()),
             7'($urandom()));
      end
    end
    stim_done = 1;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && busy) begin
      // hold word until taken
    end else begin
      if (start) begin
        alloc_exp_q.push_back(compute_alloc(pend_q.pop_front()));
        gap = pick_gap();
      end
      if (gap > 0) begin
        gap--;
        start <= 1'b0;
      end else if (pend_q.size() > 0) begin
        req_t r;
        r = pend_q[0];
        start <= 1'b1;
        in_operation <= r.op;
        in_alignment_class <= r.cls;
        in_size_bytes <= r.size;
        in_free_chunk <= r.fch;
        in_free_start <= r.fst;
        in_free_count <= r.fcnt;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (alloc_exp_q.size() == 0) begin
        $error("unexpected result word status=%0d", out_status);
        errs++;
      end else begin
        resp_t e;
        e = alloc_exp_q.pop_front();
        if (out_status != e.st) begin
          $error("status exp %0d got %0d", e.st, out_status); errs++;
        end
        if (out_chunk_id != e.ch) begin
          $error("chunk_id exp %0d got %0d", e.ch, out_chunk_id); errs++;
        end
        if (out_start_block != e.sb) begin
          $error("start_block exp %0d got %0d", e.sb, out_start_block); errs++;
        end
        if (out_block_count != e.cnt) begin
          $error("block_count exp %0d got %0d", e.cnt, out_block_count); errs++;
        end
        if (out_new_chunk != e.fresh) begin
          $error("new_chunk exp %0d got %0d", e.fresh, out_new_chunk); errs++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= WD_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done);
    while (pend_q.size() > 0 || start || alloc_exp_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errs == 0 && alloc_exp_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
